@@ rtl/core/hgrp_pkg.sv @@
// Types, constants and character helpers for the HTTP GET request parser.
`default_nettype none

package hgrp_pkg;

    typedef enum logic [3:0] {
        PH_METHOD   = 4'd0,
        PH_SEP1     = 4'd1,
        PH_URL      = 4'd2,
        PH_SEP2     = 4'd3,
        PH_VERSION  = 4'd4,
        PH_LINEFAIL = 4'd5,
        PH_KEEP     = 4'd6,
        PH_HEADER   = 4'd7,
        PH_DONE     = 4'd8,
        PH_BAD      = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        UF_UNDEC   = 2'd0,
        UF_VALID   = 2'd1,
        UF_INVALID = 2'd2,
        UF_HTTP    = 2'd3
    } t_url;

    typedef logic [4:0] t_pos;

    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_DONE       = 2'd1;
    localparam logic [1:0] ST_BAD        = 2'd2;

    localparam t_pos LEN_GET  = 5'd3;
    localparam t_pos LEN_VER  = 5'd8;
    localparam t_pos LEN_PFX  = 5'd7;
    localparam t_pos LEN_CONN = 5'd10;
    localparam t_pos KEEP_OFS = 5'd12;
    localparam t_pos KEEP_END = 5'd22;
    localparam t_pos POS_MAX  = 5'd31;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    function automatic logic [7:0] lower8(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    // Keyword letters, already lowercase
    function automatic logic [7:0] get_char(input logic [1:0] p);
        case (p)
            2'd0:    return "g";
            2'd1:    return "e";
            default: return "t";
        endcase
    endfunction

    function automatic logic [7:0] ver_char(input logic [2:0] p);
        case (p)
            3'd0:    return "h";
            3'd1:    return "t";
            3'd2:    return "t";
            3'd3:    return "p";
            3'd4:    return "/";
            3'd5:    return "1";
            3'd6:    return ".";
            default: return "0";
        endcase
    endfunction

    function automatic logic [7:0] pfx_char(input logic [2:0] p);
        case (p)
            3'd0:    return "h";
            3'd1:    return "t";
            3'd2:    return "t";
            3'd3:    return "p";
            3'd4:    return ":";
            3'd5:    return "/";
            default: return "/";
        endcase
    endfunction

    function automatic logic [7:0] conn_char(input logic [3:0] p);
        case (p)
            4'd0:    return "c";
            4'd1:    return "o";
            4'd2:    return "n";
            4'd3:    return "n";
            4'd4:    return "e";
            4'd5:    return "c";
            4'd6:    return "t";
            4'd7:    return "i";
            4'd8:    return "o";
            default: return "n";
        endcase
    endfunction

    function automatic logic [7:0] keep_char(input logic [3:0] p);
        case (p)
            4'd0:    return "k";
            4'd1:    return "e";
            4'd2:    return "e";
            4'd3:    return "p";
            4'd4:    return "-";
            4'd5:    return "a";
            4'd6:    return "l";
            4'd7:    return "i";
            4'd8:    return "v";
            default: return "e";
        endcase
    endfunction

    function automatic t_pos bump(input t_pos p);
        return (p == POS_MAX) ? p : p + 5'd1;
    endfunction

    // URL prefix tracking for one URL byte
    function automatic t_url url_next(input t_url f, input t_pos p, input logic [7:0] b);
        t_url r;
        r = f;
        if (f == UF_UNDEC) begin
            if (p == 5'd0 && b == CH_SLASH) begin
                r = UF_VALID;
            end else if (p < LEN_PFX && lower8(b) == pfx_char(p[2:0])) begin
                r = (p == LEN_PFX - 5'd1) ? UF_HTTP : UF_UNDEC;
            end else begin
                r = UF_INVALID;
            end
        end else if (f == UF_HTTP && b == CH_SLASH) begin
            r = UF_VALID;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/hgrp_req_if.sv @@
// Request channel: one stream byte with its first-byte mark.
`default_nettype none

interface hgrp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_byte;

    modport source (output valid, output byte_value, output first_byte, input ready);
    modport sink   (input valid, input byte_value, input first_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hgrp_rsp_if.sv @@
// Response channel: parse status and keep-alive flag.
`default_nettype none

interface hgrp_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       keep_alive;

    modport source (output valid, output status, output keep_alive, input ready);
    modport sink   (input valid, input status, input keep_alive, output ready);
endinterface

`default_nettype wire

@@ rtl/core/http_get_request_parser.sv @@
// HTTP/1.0 GET request parser, one byte per cycle while i_req.ready is high.
//
//  channel | dir | payload                      | handshake
//  i_req   | in  | byte_value[7:0], first_byte  | valid/ready
//  o_rsp   | out | status[1:0], keep_alive      | valid/ready
//
// One request in, one response out, valid in the cycle after its byte is accepted;
// a byte can be taken every cycle while i_req.ready is high. The parse state and
// the response register are both loaded at the accepting edge. i_req.ready drops
// only while a response is held and o_rsp.ready is low. Reset returns to the
// method phase with keep-alive cleared; first_byte clears everything but keep-alive.
`default_nettype none

module http_get_request_parser (
    input  wire        i_clk,
    input  wire        i_rst_n,
    hgrp_req_if.sink   i_req,
    hgrp_rsp_if.source o_rsp
);
    import hgrp_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_pcr, n_pcr;
    t_pos       r_pos, n_pos;
    logic       r_tm, n_tm;
    t_url       r_uf, n_uf;
    logic       r_le, n_le;
    logic       r_keep, n_keep;
    logic       r_valid;
    logic [1:0] r_status, n_status;

    logic       accept;
    logic [7:0] b;
    logic [7:0] bl;
    t_phase     c_phase;
    logic       c_pcr;
    t_pos       c_pos;
    logic       c_tm;
    t_url       c_uf;
    logic       c_le;
    t_pos       kofs;

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign b           = i_req.byte_value;
    assign bl          = lower8(b);

    always_comb begin
        // first_byte restarts the parse before this byte is looked at
        c_phase = i_req.first_byte ? PH_METHOD : r_phase;
        c_pcr   = i_req.first_byte ? 1'b0 : r_pcr;
        c_pos   = i_req.first_byte ? 5'd0 : r_pos;
        c_tm    = i_req.first_byte ? 1'b1 : r_tm;
        c_uf    = i_req.first_byte ? UF_UNDEC : r_uf;
        c_le    = i_req.first_byte ? 1'b1 : r_le;
        if (c_phase > PH_BAD) begin
            c_phase = PH_BAD;
        end
        kofs = c_pos - KEEP_OFS;

        n_phase = c_phase;
        n_pcr   = c_pcr;
        n_pos   = c_pos;
        n_tm    = c_tm;
        n_uf    = c_uf;
        n_le    = c_le;
        n_keep  = r_keep;

        if (c_phase != PH_DONE && c_phase != PH_BAD) begin
            if (c_pcr) begin
                n_pcr = 1'b0;
                if (b == CH_LF) begin
                    // end of line
                    case (c_phase)
                        PH_VERSION: begin
                            n_phase = (c_tm && c_pos == LEN_VER) ? PH_KEEP : PH_BAD;
                        end
                        PH_KEEP: begin
                            if (c_le) begin
                                n_phase = PH_DONE;
                            end else begin
                                if (c_tm && c_pos >= KEEP_END) begin
                                    n_keep = 1'b1;
                                end
                                n_phase = PH_HEADER;
                            end
                        end
                        PH_HEADER: begin
                            n_phase = c_le ? PH_DONE : PH_HEADER;
                        end
                        default: begin
                            n_phase = PH_BAD;
                        end
                    endcase
                    n_pos = 5'd0;
                    n_tm  = 1'b1;
                    n_le  = 1'b1;
                end else begin
                    n_phase = PH_BAD;
                end
            end else if (b == CH_CR) begin
                n_pcr = 1'b1;
            end else if (b == CH_LF) begin
                n_phase = PH_BAD;
            end else begin
                n_le = 1'b0;
                case (c_phase)
                    PH_METHOD: begin
                        if (is_blank(b)) begin
                            n_phase = (c_tm && c_pos == LEN_GET) ? PH_SEP1 : PH_LINEFAIL;
                        end else begin
                            n_tm  = c_tm && (c_pos < LEN_GET) && (bl == get_char(c_pos[1:0]));
                            n_pos = bump(c_pos);
                        end
                    end
                    PH_SEP1: begin
                        if (!is_blank(b)) begin
                            n_phase = PH_URL;
                            n_uf    = url_next(UF_UNDEC, 5'd0, b);
                            n_pos   = 5'd1;
                        end
                    end
                    PH_URL: begin
                        if (is_blank(b)) begin
                            n_phase = (c_uf == UF_VALID) ? PH_SEP2 : PH_LINEFAIL;
                        end else begin
                            n_uf  = url_next(c_uf, c_pos, b);
                            n_pos = bump(c_pos);
                        end
                    end
                    PH_SEP2: begin
                        if (!is_blank(b)) begin
                            n_phase = PH_VERSION;
                            n_tm    = (bl == ver_char(3'd0));
                            n_pos   = 5'd1;
                        end
                    end
                    PH_VERSION: begin
                        n_tm  = c_tm && (c_pos < LEN_VER) && (bl == ver_char(c_pos[2:0]));
                        n_pos = bump(c_pos);
                    end
                    PH_KEEP: begin
                        if (c_pos < LEN_CONN) begin
                            n_tm = c_tm && (bl == conn_char(c_pos[3:0]));
                        end else if (c_pos >= KEEP_OFS && c_pos < KEEP_END) begin
                            n_tm = c_tm && (bl == keep_char(kofs[3:0]));
                        end
                        n_pos = bump(c_pos);
                    end
                    default: begin
                    end
                endcase
            end
        end

        case (n_phase)
            PH_DONE: n_status = ST_DONE;
            PH_BAD:  n_status = ST_BAD;
            default: n_status = ST_INCOMPLETE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_pcr   <= 1'b0;
            r_pos   <= 5'd0;
            r_tm    <= 1'b1;
            r_uf    <= UF_UNDEC;
            r_le    <= 1'b1;
            r_keep  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_pcr   <= n_pcr;
                r_pos   <= n_pos;
                r_tm    <= n_tm;
                r_uf    <= n_uf;
                r_le    <= n_le;
                r_keep  <= n_keep;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.keep_alive = r_keep;

    // held status agrees with the phase it came from
    a_status_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((o_rsp.status == ST_BAD) == (r_phase == PH_BAD))
                     && ((o_rsp.status == ST_DONE) == (r_phase == PH_DONE)))
        else $error("status does not match parse phase");

    // keep-alive is sticky until reset
    a_keep_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_keep |=> r_keep)
        else $error("keep-alive flag dropped");

    // an awaited LF never outlives the end of a request
    a_pcr_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcr |-> (r_phase != PH_DONE && r_phase != PH_BAD))
        else $error("pending CR in a terminal phase");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.valid |-> i_req.ready)
        else $error("request stalled with empty output");

endmodule

`default_nettype wire
